// File: src/uartrx_pkg.sv
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types and constants for the majority-sampled UART receiver.
// ----------------------------------------------------------------------------
package uartrx_pkg;

   localparam int SYNC_STAGES = 3;
   localparam int CNT_WIDTH   = 5;
   localparam logic [CNT_WIDTH-1:0] CNT_MAX = {CNT_WIDTH{1'b1}};
   localparam int BYTE_WIDTH  = 8;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_START    = 4'd1,
      ST_BIT0     = 4'd2,
      ST_BIT1     = 4'd3,
      ST_BIT2     = 4'd4,
      ST_BIT3     = 4'd5,
      ST_BIT4     = 4'd6,
      ST_BIT5     = 4'd7,
      ST_BIT6     = 4'd8,
      ST_BIT7     = 4'd9,
      ST_STOP_ONE = 4'd10,
      ST_STOP_A   = 4'd11,
      ST_STOP_B   = 4'd12
   } frame_state_type;

   typedef struct packed {
      logic line_level;
      logic baud_tick;
      logic oversample_tick;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] received_byte;
      logic                  frame_done;
      logic                  hold_baud_gen;
   } rsp_item_type;

   typedef struct packed {
      logic baud_tick;
      logic synced;
      logic vote;
   } frame_ctl_type;

endpackage

// File: src/uartrx_sync.sv
// ----------------------------------------------------------------------------
// uartrx_sync
// Synchronizer chain for the serial line, advanced once per beat.
// ----------------------------------------------------------------------------
module uartrx_sync
   import uartrx_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic line_level,
   output logic synced
);

   logic [SYNC_STAGES-1:0] chain_ff;
   logic [SYNC_STAGES-1:0] chain_in;

   assign chain_in = {chain_ff[SYNC_STAGES-2:0], line_level};
   assign synced   = chain_ff[SYNC_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (step) begin
         chain_ff <= chain_in;
      end
   end

endmodule

// File: src/uartrx_vote.sv
// ----------------------------------------------------------------------------
// uartrx_vote
// Majority filter: counts ones and samples on oversample ticks, cleared the
// beat after a baud tick.
// ----------------------------------------------------------------------------
module uartrx_vote
   import uartrx_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic baud_tick,
   input  logic oversample_tick,
   input  logic synced,
   output logic vote
);

   logic                 clear_ff;
   logic [CNT_WIDTH-1:0] ones_ff;
   logic [CNT_WIDTH-1:0] ones_in;
   logic [CNT_WIDTH-1:0] samples_ff;
   logic [CNT_WIDTH-1:0] samples_in;

   assign vote = {ones_ff, 1'b0} > {1'b0, samples_ff};

   always_comb begin
      ones_in    = ones_ff;
      samples_in = samples_ff;
      if (clear_ff) begin
         ones_in    = '0;
         samples_in = '0;
      end else if (oversample_tick) begin
         if (samples_ff != CNT_MAX) samples_in = samples_ff + 1'b1;
         if (synced && ones_ff != CNT_MAX) ones_in = ones_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b0;
         ones_ff    <= '0;
         samples_ff <= '0;
      end else if (step) begin
         clear_ff   <= baud_tick;
         ones_ff    <= ones_in;
         samples_ff <= samples_in;
      end
   end

endmodule

// File: src/uartrx_fsm.sv
// ----------------------------------------------------------------------------
// uartrx_fsm
// Frame sequencer and receive shift register.
// ----------------------------------------------------------------------------
module uartrx_fsm
   import uartrx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          two_stop_bits,
   input  frame_ctl_type ctl,
   output rsp_item_type  result
);

   frame_state_type       state_ff;
   frame_state_type       state_in;
   logic [BYTE_WIDTH-1:0] shift_ff;
   logic [BYTE_WIDTH-1:0] shift_in;
   logic                  shift_en;
   logic                  done;
   logic                  hold;

   always_comb begin
      state_in = state_ff;
      shift_en = 1'b0;
      done     = 1'b0;
      hold     = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: begin
            hold = 1'b1;
            if (!ctl.synced) state_in = ST_START;
         end
         ST_START: begin
            if (!ctl.vote && ctl.baud_tick) state_in = ST_BIT0;
         end
         [ST_BIT0:ST_BIT6]: begin
            shift_en = 1'b1;
            if (ctl.baud_tick) state_in = frame_state_type'(state_ff + 4'd1);
         end
         ST_BIT7: begin
            shift_en = 1'b1;
            if (ctl.baud_tick) state_in = two_stop_bits ? ST_STOP_A : ST_STOP_ONE;
         end
         ST_STOP_A: begin
            if (ctl.baud_tick) state_in = ST_STOP_B;
         end
         ST_STOP_ONE, ST_STOP_B: begin
            done = 1'b1;
            if (ctl.baud_tick) state_in = ST_IDLE;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   assign shift_in = (shift_en && ctl.baud_tick) ? {ctl.vote, shift_ff[BYTE_WIDTH-1:1]}
                                                 : shift_ff;

   assign result.received_byte = shift_ff;
   assign result.frame_done    = done;
   assign result.hold_baud_gen = hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         shift_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// File: src/uart_receiver_majority_sampled_top.sv
// ----------------------------------------------------------------------------
// uart_receiver_majority_sampled_top
// UART receiver with synchronizer, majority-vote sampling and 1/2 stop bits.
//
// Channel | Direction | Handshake          | Beat
// req     | in        | req_valid/req_stall | line level, baud tick, oversample tick
// rsp     | out       | rsp_valid/rsp_stall | shift register, done, hold
// csr     | in        | csr_valid/csr_ready | two_stop_bits
//
// One beat per cycle while rsp_stall is low; a result is offered once its beat
// has passed the input register and then the result register.
// req_stall rises only while a result is held by rsp_stall and the input
// register is full; csr_ready is always high.
// Reset is synchronous and returns the frame sequencer to idle.
// ----------------------------------------------------------------------------
module uart_receiver_majority_sampled_top
   import uartrx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_payload,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic          in_vld_ff;
   req_item_type  in_data_ff;
   logic          out_vld_ff;
   rsp_item_type  out_data_ff;
   logic          two_stop_ff;
   logic          advance;
   logic          accept;
   logic          synced;
   logic          vote;
   frame_ctl_type ctl;
   rsp_item_type  result;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_data_ff;

   assign ctl.baud_tick = in_data_ff.baud_tick;
   assign ctl.synced    = synced;
   assign ctl.vote      = vote;

   uartrx_sync u_sync (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .line_level (in_data_ff.line_level),
      .synced     (synced)
   );

   uartrx_vote u_vote (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .baud_tick       (in_data_ff.baud_tick),
      .oversample_tick (in_data_ff.oversample_tick),
      .synced          (synced),
      .vote            (vote)
   );

   uartrx_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .two_stop_bits (two_stop_ff),
      .ctl           (ctl),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         two_stop_ff <= 1'b0;
      end else begin
         if (accept) in_vld_ff <= 1'b1;
         else if (advance) in_vld_ff <= 1'b0;
         if (advance) out_vld_ff <= 1'b1;
         else if (!rsp_stall) out_vld_ff <= 1'b0;
         if (csr_valid && csr_ready) two_stop_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_data_ff <= req_payload;
      if (advance) out_data_ff <= result;
   end

endmodule

// File: src/uartrx_checker.sv
// ----------------------------------------------------------------------------
// uartrx_checker
// Port-level checks for the UART receiver, bound to the top level.
// ----------------------------------------------------------------------------
module uartrx_checker
   import uartrx_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp beat changed");

   a_idle_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.hold_baud_gen && rsp_payload.frame_done))
      else $error("idle and frame done together");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a blocked rsp beat");

endmodule

bind uart_receiver_majority_sampled_top uartrx_checker u_checker (.*);

// File: tb/uart_receiver_majority_sampled_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_receiver_majority_sampled_top_tb
// Self-checking bench for the majority-sampled UART receiver. Serial frames
// with random bit periods, sample rates, payloads and line glitches, mixed
// with raw noise, are fed one line sample per beat. A cycle-accurate model of
// the synchronizer, vote counters and frame sequencer predicts every status
// beat, which is compared field by field against the block's output under
// random input gaps and output stalls, across both stop-bit settings.
// ----------------------------------------------------------------------------
module uart_receiver_majority_sampled_top_tb
   import uartrx_pkg::*;
();

   class rx_status_checker;
      frame_state_type          rx_state;
      logic [SYNC_STAGES-1:0]   sync_bits;
      logic [BYTE_WIDTH-1:0]    shift_bits;
      logic                     count_clear;
      logic [CNT_WIDTH-1:0]     ones_seen;
      logic [CNT_WIDTH-1:0]     samples_seen;
      logic                     two_stops;
      rsp_item_type             expected_status[$];
      int                       mismatches;

      function new();
         rx_state     = ST_IDLE;
         sync_bits    = '0;
         shift_bits   = '0;
         count_clear  = 1'b0;
         ones_seen    = '0;
         samples_seen = '0;
         two_stops    = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_stop_bits(logic two);
         two_stops = two;
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function void take_line_sample(req_item_type beat);
         rsp_item_type    status;
         frame_state_type rx_state_in;
         logic            synced;
         logic            vote;
         logic            shifting;
         synced      = sync_bits[SYNC_STAGES-1];
         vote        = (2 * int'(ones_seen)) > int'(samples_seen);
         rx_state_in = rx_state;
         shifting    = 1'b0;
         status.received_byte = shift_bits;
         status.frame_done    = 1'b0;
         status.hold_baud_gen = 1'b0;
         case (rx_state)
            ST_IDLE: begin
               status.hold_baud_gen = 1'b1;
               if (!synced) rx_state_in = ST_START;
            end
            ST_START: begin
               if (!vote && beat.baud_tick) rx_state_in = ST_BIT0;
            end
            ST_BIT0, ST_BIT1, ST_BIT2, ST_BIT3, ST_BIT4, ST_BIT5, ST_BIT6: begin
               shifting = 1'b1;
               if (beat.baud_tick) rx_state_in = frame_state_type'(rx_state + 4'd1);
            end
            ST_BIT7: begin
               shifting = 1'b1;
               if (beat.baud_tick) rx_state_in = two_stops ? ST_STOP_A : ST_STOP_ONE;
            end
            ST_STOP_ONE: begin
               status.frame_done = 1'b1;
               if (beat.baud_tick) rx_state_in = ST_IDLE;
            end
            ST_STOP_A: begin
               if (beat.baud_tick) rx_state_in = ST_STOP_B;
            end
            ST_STOP_B: begin
               status.frame_done = 1'b1;
               if (beat.baud_tick) rx_state_in = ST_IDLE;
            end
            default: begin
            end
         endcase
         expected_status.push_back(status);

         if (count_clear) begin
            ones_seen    = '0;
            samples_seen = '0;
         end else if (beat.oversample_tick) begin
            if (samples_seen != CNT_MAX) samples_seen++;
            if (synced && ones_seen != CNT_MAX) ones_seen++;
         end
         if (beat.baud_tick && shifting) shift_bits = {vote, shift_bits[BYTE_WIDTH-1:1]};
         count_clear = beat.baud_tick;
         sync_bits   = {sync_bits[SYNC_STAGES-2:0], beat.line_level};
         rx_state    = rx_state_in;
      endfunction

      function void check_status(rsp_item_type got);
         rsp_item_type want;
         if (expected_status.size() == 0) begin
            $error("status beat with nothing expected: %h", got);
            mismatches++;
            return;
         end
         want = expected_status.pop_front();
         if (got.received_byte !== want.received_byte) begin
            $error("received_byte expected %h actual %h", want.received_byte, got.received_byte);
            mismatches++;
         end
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done expected %b actual %b", want.frame_done, got.frame_done);
            mismatches++;
         end
         if (got.hold_baud_gen !== want.hold_baud_gen) begin
            $error("hold_baud_gen expected %b actual %b", want.hold_baud_gen, got.hold_baud_gen);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_payload;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;

   rx_status_checker checker_h;
   int               beats_sent;
   int               burst_left;
   logic             hold_off_pending;

   uart_receiver_majority_sampled_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) checker_h.check_status(rsp_payload);
         if (req_valid && !req_stall) checker_h.take_line_sample(req_payload);
         if (csr_valid && csr_ready) checker_h.set_stop_bits(csr_data);
      end
   end

   // result-side stall pattern
   initial begin
      int stall_mode;
      int mode_left;
      int hold_left;
      int phase_cnt;
      rsp_stall  = 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      phase_cnt  = 0;
      forever begin
         @(negedge clock);
         phase_cnt++;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left = 60;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (phase_cnt % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_beat(input req_item_type beat);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 48);
         repeat (gap) @(negedge clock) req_valid <= 1'b0;
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic release_req();
      @(negedge clock) req_valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic drain();
      release_req();
      while (checker_h.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_stop_bits(input logic two);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= two;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input int period, input int ovs_div, input logic [7:0] data,
                             input int stop_bits, input int lead);
      req_item_type beat;
      int           total;
      int           cyc;
      int           bitpos;
      int           tick_phase;
      logic         lvl;
      total      = (lead + 1 + 8 + stop_bits) * period;
      tick_phase = $urandom_range(0, period - 1);
      for (cyc = 0; cyc < total; cyc++) begin
         bitpos = cyc / period - lead;
         if (bitpos < 0 || bitpos > 8) lvl = 1'b1;
         else if (bitpos == 0) lvl = 1'b0;
         else lvl = data[bitpos-1];
         if ($urandom_range(0, 39) == 0) lvl = ~lvl;
         beat.line_level      = lvl;
         beat.baud_tick       = ((cyc + tick_phase) % period == period - 1);
         beat.oversample_tick = (cyc % ovs_div == 0);
         send_beat(beat);
      end
   endtask

   task automatic send_noise(input int count);
      req_item_type beat;
      repeat (count) begin
         beat.line_level      = 1'($urandom_range(0, 1));
         beat.baud_tick       = ($urandom_range(0, 7) == 0);
         beat.oversample_tick = 1'($urandom_range(0, 1));
         send_beat(beat);
      end
   endtask

   task automatic run_traffic(input int count);
      int first;
      int period;
      first = beats_sent;
      while (beats_sent - first < count) begin
         if ($urandom_range(0, 9) < 8) begin
            period = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 40) : $urandom_range(3, 12);
            send_frame(period, $urandom_range(1, 4), 8'($urandom_range(0, 255)),
                       $urandom_range(1, 2), $urandom_range(0, 2));
         end else begin
            send_noise($urandom_range(10, 40));
         end
      end
   endtask

   task automatic send_directed();
      req_item_type beat;
      int           i;
      for (i = 0; i < 8; i++) begin
         beat = req_item_type'(i[2:0]);
         send_beat(beat);
      end
      // hold the line low: start, then walk the data bits
      for (i = 0; i < 16; i++) begin
         beat.line_level      = 1'b0;
         beat.oversample_tick = 1'b1;
         beat.baud_tick       = (i % 4 == 3);
         send_beat(beat);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_valid        = 1'b0;
      csr_data         = 1'b0;
      beats_sent       = 0;
      burst_left       = 0;
      hold_off_pending = 1'b0;
      checker_h        = new();
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      write_stop_bits(1'b1);
      send_directed();
      run_traffic(350);
      drain();
      write_stop_bits(1'b0);
      hold_off_pending = 1'b1;
      run_traffic(450);
      drain();
      write_stop_bits(1'b1);
      run_traffic(450);
      drain();
      write_stop_bits(1'b0);
      run_traffic(350);
      drain();

      if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
